/* design/usd_pkg.sv */
package usd_pkg;

    localparam int unsigned CpW  = 31;
    localparam int unsigned LenW = 3;

    localparam logic [LenW-1:0] LEN_1 = 3'd1;
    localparam logic [LenW-1:0] LEN_2 = 3'd2;
    localparam logic [LenW-1:0] LEN_3 = 3'd3;
    localparam logic [LenW-1:0] LEN_4 = 3'd4;
    localparam logic [LenW-1:0] LEN_5 = 3'd5;
    localparam logic [LenW-1:0] LEN_6 = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } t_in_word;

    typedef struct packed {
        logic [CpW-1:0]  code_point;
        logic [LenW-1:0] seq_length;
        logic            invalid_lead;
        logic            truncated;
    } t_out_word;

endpackage

/* design/utf8_stream_decoder.sv */
// channel   direction  handshake                 word
// input     in         i_in_valid / o_in_stall   t_in_word  (data_byte, buffer_end)
// output    out        o_out_valid / i_out_stall t_out_word (code_point, seq_length,
//                                                 invalid_lead, truncated)
//
// One word per cycle sustained while the output is not stalled; the byte that completes a
// character passes the input register and the single decode pass into the output register.
// Synchronous active-low reset clears the decode state and both valid flags.
// A stall at the output holds the result register and, once the input register is
// full, stalls the input; nothing is lost while stalled.
module utf8_stream_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  usd_pkg::t_in_word  i_in_word,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output usd_pkg::t_out_word o_out_word,
    input  logic               i_out_stall
);

    logic               w_free;
    logic               w_cur_valid;
    usd_pkg::t_in_word  w_cur_word;
    logic               w_res_valid;
    usd_pkg::t_out_word w_res_word;

    usd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .o_stall (o_in_stall),
        .i_take  (w_free),
        .o_valid (w_cur_valid),
        .o_word  (w_cur_word)
    );

    usd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_cur_valid),
        .i_word      (w_cur_word),
        .i_advance   (w_free),
        .o_res_valid (w_res_valid),
        .o_res_word  (w_res_word)
    );

    usd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_res_valid),
        .i_word  (w_res_word),
        .o_free  (w_free),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_stall (i_out_stall)
    );

endmodule

/* design/usd_in_reg.sv */
module usd_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  usd_pkg::t_in_word i_word,
    output logic            o_stall,
    input  logic            i_take,
    output logic            o_valid,
    output usd_pkg::t_in_word o_word
);

    logic              r_valid;
    usd_pkg::t_in_word r_word;
    logic              w_load;

    assign w_load  = !r_valid || i_take;
    assign o_stall = !w_load;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* design/usd_core.sv */
module usd_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  usd_pkg::t_in_word  i_word,
    input  logic               i_advance,
    output logic               o_res_valid,
    output usd_pkg::t_out_word o_res_word
);

    logic [usd_pkg::CpW-1:0]  r_acc,   n_acc;
    logic [usd_pkg::LenW-1:0] r_left,  n_left;
    logic [usd_pkg::LenW-1:0] r_total, n_total;

    logic [7:0]               w_b;
    logic                     w_last;
    logic [usd_pkg::CpW-1:0]  w_shift;
    logic [usd_pkg::LenW-1:0] w_dec;
    logic [usd_pkg::CpW-1:0]  w_payload;
    logic [usd_pkg::LenW-1:0] w_len;
    logic                     w_bad;
    logic                     w_emit;
    usd_pkg::t_out_word       w_res;

    assign w_b     = i_word.data_byte;
    assign w_last  = i_word.buffer_end;
    assign w_shift = {r_acc[usd_pkg::CpW-7:0], w_b[5:0]};
    assign w_dec   = r_left - 3'd1;

    always_comb begin
        w_payload = '0;
        w_len     = usd_pkg::LEN_1;
        w_bad     = 1'b0;
        unique case (w_b) inside
            8'b0???????: begin
                w_payload = {{(usd_pkg::CpW-8){1'b0}}, w_b};
            end
            8'b110?????: begin
                w_payload = {{(usd_pkg::CpW-5){1'b0}}, w_b[4:0]};
                w_len     = usd_pkg::LEN_2;
            end
            8'b1110????: begin
                w_payload = {{(usd_pkg::CpW-4){1'b0}}, w_b[3:0]};
                w_len     = usd_pkg::LEN_3;
            end
            8'b11110???: begin
                w_payload = {{(usd_pkg::CpW-3){1'b0}}, w_b[2:0]};
                w_len     = usd_pkg::LEN_4;
            end
            8'b111110??: begin
                w_payload = {{(usd_pkg::CpW-2){1'b0}}, w_b[1:0]};
                w_len     = usd_pkg::LEN_5;
            end
            8'b1111110?: begin
                w_payload = {{(usd_pkg::CpW-1){1'b0}}, w_b[0]};
                w_len     = usd_pkg::LEN_6;
            end
            default: begin
                w_bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_acc   = r_acc;
        n_left  = r_left;
        n_total = r_total;
        w_emit  = 1'b0;
        w_res   = '0;
        if (r_left == '0) begin
            if (w_bad) begin
                w_emit             = 1'b1;
                w_res.seq_length   = usd_pkg::LEN_1;
                w_res.invalid_lead = 1'b1;
            end else if (w_len == usd_pkg::LEN_1) begin
                w_emit           = 1'b1;
                w_res.code_point = w_payload;
                w_res.seq_length = usd_pkg::LEN_1;
            end else if (w_last) begin
                w_emit           = 1'b1;
                w_res.seq_length = usd_pkg::LEN_1;
                w_res.truncated  = 1'b1;
            end else begin
                n_acc   = w_payload;
                n_total = w_len;
                n_left  = w_len - 3'd1;
            end
        end else if (w_dec == '0) begin
            w_emit           = 1'b1;
            w_res.code_point = w_shift;
            w_res.seq_length = r_total;
            n_acc            = '0;
            n_left           = '0;
            n_total          = '0;
        end else if (w_last) begin
            w_emit           = 1'b1;
            w_res.seq_length = r_total - w_dec;
            w_res.truncated  = 1'b1;
            n_acc            = '0;
            n_left           = '0;
            n_total          = '0;
        end else begin
            n_acc  = w_shift;
            n_left = w_dec;
        end
    end

    assign o_res_valid = i_valid && w_emit;
    assign o_res_word  = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_left  <= '0;
            r_total <= '0;
        end else if (i_valid && i_advance) begin
            r_acc   <= n_acc;
            r_left  <= n_left;
            r_total <= n_total;
        end
    end

endmodule

/* design/usd_out_reg.sv */
module usd_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  usd_pkg::t_out_word i_word,
    output logic               o_free,
    output logic               o_valid,
    output usd_pkg::t_out_word o_word,
    input  logic               i_stall
);

    logic               r_valid;
    usd_pkg::t_out_word r_word;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_word <= i_word;
        end
    end

endmodule

/* test/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned HoldCycles    = 300;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    usd_pkg::t_in_word  i_in_word   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    usd_pkg::t_out_word o_out_word;
    logic               i_out_stall = 1'b0;

    utf8_stream_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // decoder state mirrored by the predictor
    logic [usd_pkg::CpW-1:0]  dec_acc   = '0;
    logic [usd_pkg::LenW-1:0] dec_left  = '0;
    logic [usd_pkg::LenW-1:0] dec_total = '0;

    usd_pkg::t_out_word chars_expected[$];
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned hold_order   = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_errors     = 0;
    int unsigned n_bytes      = 0;
    int unsigned n_chars      = 0;
    int unsigned n_invalid    = 0;
    int unsigned n_trunc      = 0;
    usd_pkg::t_out_word exp_word;

    function automatic bit decode_byte(input usd_pkg::t_in_word w,
                                       output usd_pkg::t_out_word r);
        logic [usd_pkg::CpW-1:0]  payload;
        logic [usd_pkg::LenW-1:0] total;
        r = '0;
        payload = '0;
        total = '0;
        if (dec_left == 0) begin
            if (!w.data_byte[7]) begin
                r.code_point = usd_pkg::CpW'(w.data_byte);
                r.seq_length = usd_pkg::LEN_1;
                return 1'b1;
            end else if (w.data_byte[7:5] == 3'b110) begin
                payload = usd_pkg::CpW'(w.data_byte[4:0]);
                total = usd_pkg::LEN_2;
            end else if (w.data_byte[7:4] == 4'b1110) begin
                payload = usd_pkg::CpW'(w.data_byte[3:0]);
                total = usd_pkg::LEN_3;
            end else if (w.data_byte[7:3] == 5'b11110) begin
                payload = usd_pkg::CpW'(w.data_byte[2:0]);
                total = usd_pkg::LEN_4;
            end else if (w.data_byte[7:2] == 6'b111110) begin
                payload = usd_pkg::CpW'(w.data_byte[1:0]);
                total = usd_pkg::LEN_5;
            end else if (w.data_byte[7:1] == 7'b1111110) begin
                payload = usd_pkg::CpW'(w.data_byte[0]);
                total = usd_pkg::LEN_6;
            end else begin
                r.seq_length = usd_pkg::LEN_1;
                r.invalid_lead = 1'b1;
                return 1'b1;
            end
            if (w.buffer_end) begin
                r.seq_length = usd_pkg::LEN_1;
                r.truncated = 1'b1;
                return 1'b1;
            end
            dec_acc = payload;
            dec_total = total;
            dec_left = total - 3'd1;
            return 1'b0;
        end
        dec_acc = {dec_acc[usd_pkg::CpW-7:0], w.data_byte[5:0]};
        dec_left = dec_left - 3'd1;
        if (dec_left == 0) begin
            r.code_point = dec_acc;
            r.seq_length = dec_total;
        end else if (w.buffer_end) begin
            r.seq_length = dec_total - dec_left;
            r.truncated = 1'b1;
        end else begin
            return 1'b0;
        end
        dec_acc = '0;
        dec_left = '0;
        dec_total = '0;
        return 1'b1;
    endfunction

    task automatic send_word(input logic [7:0] data, input logic last);
        usd_pkg::t_in_word  w;
        usd_pkg::t_out_word r;
        w.data_byte = data;
        w.buffer_end = last;
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        n_bytes++;
        if (decode_byte(w, r))
            chars_expected.push_back(r);
    endtask

    task automatic send_random_char(input int unsigned len, output int unsigned used);
        logic [7:0] lead;
        case (len)
            1:       lead = {1'b0, 7'($urandom)};
            2:       lead = {3'b110, 5'($urandom)};
            3:       lead = {4'b1110, 4'($urandom)};
            4:       lead = {5'b11110, 3'($urandom)};
            5:       lead = {6'b111110, 2'($urandom)};
            default: lead = {7'b1111110, 1'($urandom)};
        endcase
        send_word(lead, $urandom_range(29) == 0);
        for (int k = 1; k < len; k++)
            send_word({2'b10, 6'($urandom)}, $urandom_range(29) == 0);
        used = len;
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE2, 8'h82, 8'hAC,
                8'hF4, 8'h8F, 8'hBF, 8'hBF,
                8'hFB, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
                8'h80, 8'hFE, 8'hFF, 8'hC3, 8'hE2, 8'h41};
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        foreach (seq[k])
            send_word(seq[k], k == 1 || k == 10 || k == 25 || k == 27);
    endtask

    task automatic test_random_stream(input int unsigned n_items, input int unsigned snd_pct,
                                      input int unsigned rcv_pct);
        int unsigned sent;
        int unsigned used;
        sent = 0;
        snd_idle_pct = snd_pct;
        rcv_idle_pct <= rcv_pct;
        while (sent < n_items) begin
            if ($urandom_range(9) == 0) begin
                send_word(8'($urandom), $urandom_range(3) == 0);
                sent++;
            end else begin
                send_random_char($urandom_range(1, 6), used);
                sent += used;
            end
        end
    endtask

    task automatic test_output_hold();
        int unsigned used;
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        hold_order <= hold_order + 1;
        for (int k = 0; k < 12; k++)
            send_random_char($urandom_range(1, 6), used);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_order != hold_seen) begin
            hold_seen <= hold_order;
            hold_left <= HoldCycles;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (chars_expected.size() == 0) begin
                $display("%0t: unexpected word: expected none, got %h", $time, o_out_word);
                n_errors++;
            end else begin
                exp_word = chars_expected.pop_front();
                n_chars++;
                if (exp_word.invalid_lead)
                    n_invalid++;
                if (exp_word.truncated)
                    n_trunc++;
                if (o_out_word.code_point !== exp_word.code_point) begin
                    $display("%0t: code_point expected %h got %h", $time,
                             exp_word.code_point, o_out_word.code_point);
                    n_errors++;
                end
                if (o_out_word.seq_length !== exp_word.seq_length) begin
                    $display("%0t: seq_length expected %0d got %0d", $time,
                             exp_word.seq_length, o_out_word.seq_length);
                    n_errors++;
                end
                if (o_out_word.invalid_lead !== exp_word.invalid_lead) begin
                    $display("%0t: invalid_lead expected %b got %b", $time,
                             exp_word.invalid_lead, o_out_word.invalid_lead);
                    n_errors++;
                end
                if (o_out_word.truncated !== exp_word.truncated) begin
                    $display("%0t: truncated expected %b got %b", $time,
                             exp_word.truncated, o_out_word.truncated);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t: timeout, %0d words still expected", $time, chars_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_stream(370, 11, 52);
        test_random_stream(370, 52, 11);
        test_random_stream(370, 0, 0);
        test_output_hold();
        i_in_valid <= 1'b0;
        while (chars_expected.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes; checked %0d characters (%0d invalid leads, %0d truncated).",
                 n_bytes, n_chars, n_invalid, n_trunc);
        $display("Covered all lead classes, buffer ends, three idling mixes and one long hold.");
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/usd_pkg.sv
design/usd_in_reg.sv
design/usd_core.sv
design/usd_out_reg.sv
design/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
